[sv/shell_word_splitter_top_defines.svh]
// assertion macros shared by the splitter modules
`ifndef SHELL_WORD_SPLITTER_TOP_DEFINES_SVH
`define SHELL_WORD_SPLITTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shell word splitter check failed");
`define SWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shell word splitter check failed");
`else
`define SWS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/sws_pkg.sv]
`default_nettype none
package sws_pkg;

  localparam int MAX_TOKENS = 1024;
  localparam int COUNT_W = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_TOKENS);

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TOKEN_END = 2'd1;
  localparam logic [1:0] KIND_UNMATCHED = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  // input operations
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_EMPTY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMENTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPAND = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_HASH = 8'h23;

  typedef struct packed {
    logic keep_empty;
    logic comments;
    logic expand;
    logic strip;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data;
    logic [COUNT_W-1:0] count;
  } result_t;

  // up to two results per transaction, r0 first
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } bundle_t;

  typedef struct packed {
    logic hit;
    logic [7:0] code;
  } esc_t;

  function automatic esc_t esc_lookup(input logic [7:0] c);
    esc_t e;
    e.hit = 1'b1;
    case (c)
      8'h61: e.code = 8'd7;
      8'h62: e.code = 8'd8;
      8'h65: e.code = 8'd27;
      8'h66: e.code = 8'd12;
      8'h6e: e.code = 8'd10;
      8'h72: e.code = 8'd13;
      8'h74: e.code = 8'd9;
      8'h76: e.code = 8'd11;
      default: begin
        e.hit = 1'b0;
        e.code = 8'd0;
      end
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

[sv/sws_front.sv]
`default_nettype none
module sws_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic [sws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                          cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_op,
  input  wire logic [7:0]                    in_char,
  input  wire logic                          q_full,
  output logic                               in_ready,
  output logic                               push,
  output sws_pkg::bundle_t                   push_bundle
);

  sws_pkg::cfg_t cfg_r;
  logic in_single_r, in_single_nxt;
  logic in_double_r, in_double_nxt;
  logic esc_r, esc_nxt;
  logic has_r, has_nxt;
  logic comment_r, comment_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] prev2_r, prev2_nxt;
  logic [sws_pkg::COUNT_W-1:0] total_r, total_nxt;
  logic accept;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign push = accept && (push_bundle.num != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sws_pkg::CFG_KEEP_EMPTY: cfg_r.keep_empty <= cfg_data;
        sws_pkg::CFG_COMMENTS:   cfg_r.comments <= cfg_data;
        sws_pkg::CFG_EXPAND:     cfg_r.expand <= cfg_data;
        sws_pkg::CFG_STRIP:      cfg_r.strip <= cfg_data;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    logic ws;
    logic quote;
    logic [sws_pkg::COUNT_W-1:0] inc;
    sws_pkg::esc_t e;
    ws = (in_char == sws_pkg::CH_SPACE) || (in_char == sws_pkg::CH_TAB) ||
         (in_char == sws_pkg::CH_LF) || (in_char == sws_pkg::CH_CR);
    quote = (in_char == sws_pkg::CH_SQUOTE) || (in_char == sws_pkg::CH_DQUOTE);
    inc = (total_r < sws_pkg::MAX_COUNT) ? total_r + 1'b1 : total_r;
    e = sws_pkg::esc_lookup(in_char);

    in_single_nxt = in_single_r;
    in_double_nxt = in_double_r;
    esc_nxt = esc_r;
    has_nxt = has_r;
    comment_nxt = comment_r;
    prev_nxt = prev_r;
    prev2_nxt = prev2_r;
    total_nxt = total_r;

    push_bundle.num = 2'd0;
    push_bundle.r0.kind = sws_pkg::KIND_BYTE;
    push_bundle.r0.data = in_char;
    push_bundle.r0.count = total_r;
    push_bundle.r1.kind = sws_pkg::KIND_BYTE;
    push_bundle.r1.data = in_char;
    push_bundle.r1.count = total_r;

    if (in_op == sws_pkg::OP_END) begin
      push_bundle.r0.data = 8'd0;
      push_bundle.r1.data = 8'd0;
      push_bundle.r1.kind = sws_pkg::KIND_DONE;
      if (!in_single_r && !in_double_r && !esc_r) begin
        if (has_r) begin
          push_bundle.num = 2'd2;
          push_bundle.r0.kind = sws_pkg::KIND_TOKEN_END;
          push_bundle.r0.count = inc;
          push_bundle.r1.count = inc;
        end else begin
          push_bundle.num = 2'd1;
          push_bundle.r0.kind = sws_pkg::KIND_DONE;
        end
      end else if (has_r) begin
        push_bundle.num = 2'd2;
        push_bundle.r0.kind = sws_pkg::KIND_UNMATCHED;
      end else begin
        push_bundle.num = 2'd1;
        push_bundle.r0.kind = sws_pkg::KIND_DONE;
      end
      in_single_nxt = 1'b0;
      in_double_nxt = 1'b0;
      esc_nxt = 1'b0;
      has_nxt = 1'b0;
      comment_nxt = 1'b0;
      prev_nxt = 8'd0;
      prev2_nxt = 8'd0;
      total_nxt = '0;
    end else if (!comment_r) begin
      prev2_nxt = prev_r;
      prev_nxt = in_char;
      if (esc_r) begin
        esc_nxt = 1'b0;
        has_nxt = 1'b1;
        if (ws || quote) begin
          push_bundle.num = 2'd2;
          push_bundle.r0.data = sws_pkg::CH_BSLASH;
        end else if (in_char == sws_pkg::CH_BSLASH) begin
          push_bundle.num = cfg_r.strip ? 2'd1 : 2'd2;
          push_bundle.r0.data = sws_pkg::CH_BSLASH;
        end else if (cfg_r.expand && e.hit) begin
          push_bundle.num = 2'd1;
          push_bundle.r0.data = e.code;
        end else if (cfg_r.strip) begin
          push_bundle.num = 2'd1;
        end else begin
          push_bundle.num = 2'd2;
          push_bundle.r0.data = sws_pkg::CH_BSLASH;
        end
      end else if (ws) begin
        if (in_single_r || in_double_r) begin
          push_bundle.num = 2'd1;
          has_nxt = 1'b1;
        end else if (has_r) begin
          push_bundle.num = 2'd1;
          push_bundle.r0.kind = sws_pkg::KIND_TOKEN_END;
          push_bundle.r0.data = 8'd0;
          push_bundle.r0.count = inc;
          total_nxt = inc;
          has_nxt = 1'b0;
        end
      end else if (quote) begin
        if ((in_char == sws_pkg::CH_SQUOTE) ? in_double_r : in_single_r) begin
          push_bundle.num = 2'd1;
          has_nxt = 1'b1;
        end else begin
          if (((in_char == sws_pkg::CH_SQUOTE) ? in_single_r : in_double_r) &&
              !has_r && cfg_r.keep_empty) begin
            push_bundle.num = 2'd1;
            push_bundle.r0.kind = sws_pkg::KIND_TOKEN_END;
            push_bundle.r0.data = 8'd0;
            push_bundle.r0.count = inc;
            total_nxt = inc;
          end
          if (in_char == sws_pkg::CH_SQUOTE) begin
            in_single_nxt = !in_single_r;
          end else begin
            in_double_nxt = !in_double_r;
          end
        end
      end else if (in_char == sws_pkg::CH_BSLASH) begin
        esc_nxt = 1'b1;
        has_nxt = 1'b1;
      end else if (cfg_r.comments && (in_char == sws_pkg::CH_HASH) &&
                   (prev_r == sws_pkg::CH_SPACE) && (prev2_r != sws_pkg::CH_BSLASH) &&
                   !in_single_r && !in_double_r && !has_r) begin
        comment_nxt = 1'b1;
      end else begin
        push_bundle.num = 2'd1;
        has_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_single_r <= 1'b0;
      in_double_r <= 1'b0;
      esc_r <= 1'b0;
      has_r <= 1'b0;
      comment_r <= 1'b0;
      prev_r <= 8'd0;
      prev2_r <= 8'd0;
      total_r <= '0;
    end else if (accept) begin
      in_single_r <= in_single_nxt;
      in_double_r <= in_double_nxt;
      esc_r <= esc_nxt;
      has_r <= has_nxt;
      comment_r <= comment_nxt;
      prev_r <= prev_nxt;
      prev2_r <= prev2_nxt;
      total_r <= total_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/sws_queue.sv]
`default_nettype none
`include "shell_word_splitter_top_defines.svh"
module sws_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire sws_pkg::bundle_t push_bundle,
  input  wire logic       pop,
  output logic            full,
  output logic            empty,
  output sws_pkg::bundle_t head
);

  sws_pkg::bundle_t slot_r [sws_pkg::QUEUE_DEPTH];
  logic [sws_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [sws_pkg::QCNT_W-1:0] cnt_r;

  assign full = (cnt_r == sws_pkg::QCNT_W'(sws_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `SWS_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full)
  `SWS_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !empty)
  `SWS_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= sws_pkg::QCNT_W'(sws_pkg::QUEUE_DEPTH))
  `SWS_ASSERT_NOW(a_nonempty_entry, clk, rst_n, push, push_bundle.num != 2'd0)

endmodule
`default_nettype wire

[sv/sws_back.sv]
`default_nettype none
`include "shell_word_splitter_top_defines.svh"
module sws_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire sws_pkg::bundle_t            head,
  output logic                             pop,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [1:0]                       out_kind,
  output logic [7:0]                       out_byte,
  output logic [sws_pkg::COUNT_W-1:0]      out_count,
  output logic                             out_last
);

  logic sel_r;
  logic valid_r;
  sws_pkg::result_t res_r;
  logic last_r;
  sws_pkg::result_t cur;
  logic cur_last;
  logic load;

  assign cur = sel_r ? head.r1 : head.r0;
  assign cur_last = sel_r || (head.num == 2'd1);
  assign load = !q_empty && (!valid_r || out_ready);
  assign pop = load && cur_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      sel_r <= !cur_last;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= cur;
      last_r <= cur_last;
    end
  end

  assign out_valid = valid_r;
  assign out_kind = res_r.kind;
  assign out_byte = res_r.data;
  assign out_count = res_r.count;
  assign out_last = last_r;

  `SWS_ASSERT_NOW(a_sel_has_head, clk, rst_n, sel_r, !q_empty && (head.num == 2'd2))
  `SWS_ASSERT_NEXT(a_pop_marks_last, clk, rst_n, pop, out_valid && out_last)

endmodule
`default_nettype wire

[sv/shell_word_splitter_top.sv]
`default_nettype none
// shell-style word splitter: one byte transaction per cycle on in_*, tuser 1 marks end of
// string. each transaction yields zero, one or two results on out_*, one result per cycle
// while out_tready is high; a byte transaction with a single result sustains one per cycle,
// two-result transactions (held backslash resolved, end of string after a word) go out
// one at a time. the front parser updates its state in the accepting cycle and writes its
// results as one entry into a four-entry queue; input stalls only when that queue is full.
// each result then passes the output register. config writes must only happen idle.
module shell_word_splitter_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                          cfg_data,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // char_byte
  input  wire logic                          in_tuser,   // operation
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [23:0]                        out_tdata,  // out_byte, word_count, zero pad
  output logic [1:0]                         out_tuser,  // kind
  output logic                               out_tlast   // last
);

  logic q_full, q_empty, push, pop;
  sws_pkg::bundle_t push_bundle, head;
  logic [7:0] res_byte;
  logic [sws_pkg::COUNT_W-1:0] res_count;

  assign cfg_ready = 1'b1;

  sws_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_tvalid),
    .in_op      (in_tuser),
    .in_char    (in_tdata),
    .q_full     (q_full),
    .in_ready   (in_tready),
    .push       (push),
    .push_bundle(push_bundle)
  );

  sws_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_bundle(push_bundle),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (head)
  );

  sws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_kind  (out_tuser),
    .out_byte  (res_byte),
    .out_count (res_count),
    .out_last  (out_tlast)
  );

  assign out_tdata = {5'd0, res_count, res_byte};

endmodule
`default_nettype wire

[tb/shell_word_splitter_top_tb.sv]
module shell_word_splitter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]                  kind;
    logic [7:0]                  data;
    logic [sws_pkg::COUNT_W-1:0] count;
    logic                        last;
  } token_result_t;

  localparam logic [7:0] ESC_LETTER [8] = '{"a", "b", "e", "f", "n", "r", "t", "v"};
  localparam logic [7:0] ESC_CODE [8] = '{8'd7, 8'd8, 8'd27, 8'd12, 8'd10, 8'd13, 8'd9, 8'd11};
  localparam logic [sws_pkg::CFG_IDX_W-1:0] REG_ORDER [4] = '{
    sws_pkg::CFG_KEEP_EMPTY, sws_pkg::CFG_COMMENTS, sws_pkg::CFG_EXPAND, sws_pkg::CFG_STRIP};

  class splitter_scoreboard;
    logic keep_empty, comments, expand, strip;
    logic in_sq, in_dq, bs_held, has_bytes, in_comment;
    logic [7:0] last_ch, last2_ch;
    logic [sws_pkg::COUNT_W-1:0] n_words;
    token_result_t step_q[$];
    token_result_t expected_results[$];
    int mismatches;

    function new();
      keep_empty = 0;
      comments = 0;
      expand = 0;
      strip = 0;
      mismatches = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      in_sq = 0;
      in_dq = 0;
      bs_held = 0;
      has_bytes = 0;
      in_comment = 0;
      last_ch = 8'h00;
      last2_ch = 8'h00;
      n_words = '0;
    endfunction

    function void set_reg(logic [sws_pkg::CFG_IDX_W-1:0] idx, logic v);
      case (idx)
        sws_pkg::CFG_KEEP_EMPTY: keep_empty = v;
        sws_pkg::CFG_COMMENTS: comments = v;
        sws_pkg::CFG_EXPAND: expand = v;
        sws_pkg::CFG_STRIP: strip = v;
        default: ;
      endcase
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] data);
      token_result_t r;
      if (step_q.size() >= 3) return;
      r.kind = kind;
      r.data = data;
      r.count = n_words;
      r.last = 1'b0;
      step_q.push_back(r);
    endfunction

    function void end_word();
      if (n_words < sws_pkg::MAX_COUNT) n_words = n_words + 1'b1;
      emit(sws_pkg::KIND_TOKEN_END, 8'h00);
      has_bytes = 0;
    endfunction

    function int escape_index(logic [7:0] c);
      for (int i = 0; i < 8; i++) begin
        if (ESC_LETTER[i] == c) return i;
      end
      return -1;
    endfunction

    function void quote_char(logic [7:0] c, bit is_single);
      logic own, other;
      own = is_single ? in_sq : in_dq;
      other = is_single ? in_dq : in_sq;
      if (other) begin
        emit(sws_pkg::KIND_BYTE, c);
        has_bytes = 1;
        return;
      end
      if (own && !has_bytes && keep_empty) end_word();
      if (is_single) in_sq = !in_sq;
      else in_dq = !in_dq;
    endfunction

    function void char_in(logic [7:0] c);
      bit ws, quote;
      int hit;
      ws = (c == sws_pkg::CH_SPACE) || (c == sws_pkg::CH_TAB) ||
           (c == sws_pkg::CH_LF) || (c == sws_pkg::CH_CR);
      quote = (c == sws_pkg::CH_SQUOTE) || (c == sws_pkg::CH_DQUOTE);
      if (in_comment) return;
      if (bs_held) begin
        bs_held = 0;
        if (ws || quote) begin
          emit(sws_pkg::KIND_BYTE, sws_pkg::CH_BSLASH);
          emit(sws_pkg::KIND_BYTE, c);
        end else if (c == sws_pkg::CH_BSLASH) begin
          if (!strip) emit(sws_pkg::KIND_BYTE, sws_pkg::CH_BSLASH);
          emit(sws_pkg::KIND_BYTE, sws_pkg::CH_BSLASH);
        end else begin
          hit = expand ? escape_index(c) : -1;
          if (hit >= 0) begin
            emit(sws_pkg::KIND_BYTE, ESC_CODE[hit]);
          end else begin
            if (!strip) emit(sws_pkg::KIND_BYTE, sws_pkg::CH_BSLASH);
            emit(sws_pkg::KIND_BYTE, c);
          end
        end
        has_bytes = 1;
      end else if (ws) begin
        if (in_sq || in_dq) begin
          emit(sws_pkg::KIND_BYTE, c);
          has_bytes = 1;
        end else if (has_bytes) begin
          end_word();
        end
      end else if (c == sws_pkg::CH_SQUOTE) begin
        quote_char(c, 1'b1);
      end else if (c == sws_pkg::CH_DQUOTE) begin
        quote_char(c, 1'b0);
      end else if (c == sws_pkg::CH_BSLASH) begin
        bs_held = 1;
        has_bytes = 1;
      end else if (comments && c == sws_pkg::CH_HASH && last_ch == sws_pkg::CH_SPACE &&
                   last2_ch != sws_pkg::CH_BSLASH && !in_sq && !in_dq && !has_bytes) begin
        in_comment = 1;
      end else begin
        emit(sws_pkg::KIND_BYTE, c);
        has_bytes = 1;
      end
      last2_ch = last_ch;
      last_ch = c;
    endfunction

    function void end_in();
      if (!in_sq && !in_dq && !bs_held) begin
        if (has_bytes) end_word();
      end else if (has_bytes) begin
        emit(sws_pkg::KIND_UNMATCHED, 8'h00);
      end
      emit(sws_pkg::KIND_DONE, 8'h00);
      clear_parse();
    endfunction

    function void note_item(logic op, logic [7:0] ch);
      step_q.delete();
      if (op == sws_pkg::OP_END) end_in();
      else char_in(ch);
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
      foreach (step_q[i]) expected_results.push_back(step_q[i]);
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data,
                               logic [sws_pkg::COUNT_W-1:0] count, logic last);
      token_result_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d byte %02h count %0d last %0d",
                   kind, data, count, last);
        return;
      end
      e = expected_results.pop_front();
      if (e.kind !== kind || e.data !== data || e.count !== count || e.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch kind/byte/count/last: exp %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d",
                   e.kind, e.data, e.count, e.last, kind, data, count, last);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [sws_pkg::CFG_IDX_W-1:0] cfg_index;
  logic cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  int gap_pct = 0;
  int stall_pct = 0;
  splitter_scoreboard sb = new();

  shell_word_splitter_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("shell_word_splitter_top_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata[7:0], out_tdata[8 +: sws_pkg::COUNT_W],
                        out_tlast);
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic op, input logic [7:0] ch);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= ch;
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, ch);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(sws_pkg::OP_CHAR, s[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(input logic [3:0] regs);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data <= regs[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(REG_ORDER[i], regs[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    string pool;
    pool = "abefnrtvxq0";
    r = $urandom_range(99);
    if (r < 35) return pool[$urandom_range(pool.len() - 1)];
    if (r < 45) return sws_pkg::CH_SPACE;
    if (r < 50) begin
      case ($urandom_range(2))
        0: return sws_pkg::CH_TAB;
        1: return sws_pkg::CH_LF;
        default: return sws_pkg::CH_CR;
      endcase
    end
    if (r < 56) return sws_pkg::CH_SQUOTE;
    if (r < 62) return sws_pkg::CH_DQUOTE;
    if (r < 74) return sws_pkg::CH_BSLASH;
    if (r < 82) return sws_pkg::CH_HASH;
    return 8'($urandom_range(255));
  endfunction

  task automatic run_phase(input logic [3:0] regs, input int gap, input int stall, input int n);
    int sent;
    int len;
    bit paused;
    settle();
    program_regs(regs);
    gap_pct = gap;
    stall_pct = stall;
    sent = 0;
    paused = 0;
    while (sent < n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(8, 1);
      repeat (len) begin
        send_item(sws_pkg::OP_CHAR, pick_char());
        sent++;
      end
      if ($urandom_range(99) < 85) begin
        send_item(sws_pkg::OP_END, 8'($urandom_range(255)));
        sent++;
      end
      if (!paused && sent >= n / 2) begin
        wait_drained();
        paused = 1;
      end
    end
    send_item(sws_pkg::OP_END, 8'($urandom_range(255)));
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= sws_pkg::CFG_KEEP_EMPTY;
    cfg_data <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'h00;
    in_tuser <= sws_pkg::OP_CHAR;
    out_tready <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: all options on
    program_regs(4'b1111);
    send_text("#x #q");
    send_item(sws_pkg::OP_END, 8'hff);
    send_text("\\ \\\\\\n\\\"");
    send_item(sws_pkg::OP_CHAR, 8'h00);
    send_item(sws_pkg::OP_CHAR, 8'hff);
    send_text(" '' \"a");
    send_item(sws_pkg::OP_END, 8'h00);
    send_text("\\");
    send_item(sws_pkg::OP_END, 8'h00);

    run_phase(4'b0000, 0, 0, 35);
    run_phase(4'b1111, 45, 0, 35);
    run_phase(4'b0101, 0, 45, 35);
    run_phase(4'b1010, 8, 8, 35);
    run_phase(4'($urandom_range(15)), 0, 0, 35);
    run_phase(4'($urandom_range(15)), 45, 45, 35);

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("shell_word_splitter_top_tb: clean");
    end else begin
      $display("shell_word_splitter_top_tb: errors");
    end
    $finish;
  end

endmodule
